// ----- hw/rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// shared sizes, codes and beat types of the sorted record table
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int ENTRIES     = 64;
  localparam int NAME_BYTES  = 64;
  localparam int PHONE_BYTES = 32;

  localparam int ENT_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int NAME_IW  = $clog2(NAME_BYTES);
  localparam int PHONE_IW = $clog2(PHONE_BYTES);
  localparam int BYTE_IW  = (NAME_IW > PHONE_IW) ? NAME_IW : PHONE_IW;
  localparam int NFILL_W  = $clog2(NAME_BYTES + 1);
  localparam int PFILL_W  = $clog2(PHONE_BYTES + 1);
  localparam int NAME_AW  = ENT_W + NAME_IW;
  localparam int PHONE_AW = ENT_W + PHONE_IW;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_NAME   = 2'd1;
  localparam logic [1:0] OP_PHONE  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FOUND     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       part;
    logic [7:0] char_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] count_now;
  } out_t;

  typedef struct packed {
    logic               go;
    logic [1:0]         op;
    logic [NFILL_W-1:0] name_fill;
    logic [PFILL_W-1:0] phone_fill;
  } op_req_t;

endpackage

// ----- hw/rtl/sst_ram.sv -----
// ----------------------------------------------------------------------------
// sst_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/sst_ctrl.sv -----
// ----------------------------------------------------------------------------
// sst_ctrl
// byte serial sequencer over the name and phone stores: compare, shift, write
// ----------------------------------------------------------------------------
module sst_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  sst_pkg::op_req_t             req,
  input  logic [7:0]                   qname_rd,
  input  logic [7:0]                   qphone_rd,
  output logic [sst_pkg::BYTE_IW-1:0]  qidx,
  output logic                         busy,
  output logic                         done,
  output sst_pkg::out_t                result
);
  import sst_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CMP, S_SH_RD, S_SH_WR, S_WQ_RD, S_WQ_WR
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ent;
  logic [BYTE_IW-1:0] j;
  logic               ph;
  logic               ins;

  logic [ENT_W-1:0]    rd_ent;
  logic [ENT_W-1:0]    wr_ent;
  logic [NAME_AW-1:0]  n_raddr, n_waddr;
  logic [PHONE_AW-1:0] p_raddr, p_waddr;
  logic [7:0]          name_rd, phone_rd, stored, qbyte, n_wdata, p_wdata;
  logic                n_we, p_we, field_end, j_in_fill, wr_state;
  logic                done_next;

  // insert walks entry ent-1 against the query; search walks entry ent
  assign rd_ent  = ins ? ENT_W'(ent - 1'b1) : ENT_W'(ent);
  assign wr_ent  = ENT_W'(ent);
  assign n_raddr = {rd_ent, j[NAME_IW-1:0]};
  assign n_waddr = {wr_ent, j[NAME_IW-1:0]};
  assign p_raddr = {rd_ent, j[PHONE_IW-1:0]};
  assign p_waddr = {wr_ent, j[PHONE_IW-1:0]};
  assign qidx    = j;

  always_comb begin
    j_in_fill = ph ? (PFILL_W'(j[PHONE_IW-1:0]) < req.phone_fill)
                   : (NFILL_W'(j[NAME_IW-1:0]) < req.name_fill);
    field_end = ph ? (j[PHONE_IW-1:0] == PHONE_IW'(PHONE_BYTES - 1))
                   : (j[NAME_IW-1:0] == NAME_IW'(NAME_BYTES - 1));
    qbyte     = j_in_fill ? (ph ? qphone_rd : qname_rd) : 8'd0;
    stored    = ph ? phone_rd : name_rd;
    wr_state  = (state == S_SH_WR) || (state == S_WQ_WR);
    n_we      = wr_state && !ph;
    p_we      = wr_state && ph;
    n_wdata   = (state == S_SH_WR) ? name_rd : qbyte;
    p_wdata   = (state == S_SH_WR) ? phone_rd : qbyte;
  end

  // result strobe: insert into a full table or search of an empty table at once, end of search, end of write
  always_comb begin
    done_next = 1'b0;
    if ((state == S_IDLE) && req.go) begin
      done_next = (req.op == OP_INSERT) ? (count == CNT_W'(ENTRIES)) : (count == '0);
    end else if ((state == S_CMP) && !ins) begin
      done_next = (stored != qbyte) ? (CNT_W'(ent + 1'b1) == count) : field_end;
    end else if (state == S_WQ_WR) begin
      done_next = field_end && ph;
    end
  end

  sst_ram #(.DEPTH(ENTRIES * (2 ** NAME_IW)), .WIDTH(8)) u_name (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(name_rd)
  );

  sst_ram #(.DEPTH(ENTRIES * (2 ** PHONE_IW)), .WIDTH(8)) u_phone (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(phone_rd)
  );

  assign busy = (state != S_IDLE) || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      ent   <= '0;
      j     <= '0;
      ph    <= 1'b0;
      ins   <= 1'b0;
    end else begin
      done <= done_next;
      unique case (state)
        S_IDLE: begin
          if (req.go) begin
            j   <= '0;
            ph  <= (req.op == OP_PHONE);
            ins <= (req.op == OP_INSERT);
            if (req.op == OP_INSERT) begin
              if (count == CNT_W'(ENTRIES)) begin
                result <= '{ST_FULL, 6'd0, 7'(count)};
              end else begin
                ent   <= count;
                state <= (count == '0) ? S_WQ_RD : S_RD;
              end
            end else begin
              ent <= '0;
              if (count == '0) begin
                result <= '{ST_NOT_FOUND, 6'd0, 7'(count)};
              end else begin
                state <= S_RD;
              end
            end
          end
        end
        S_RD: state <= S_CMP;
        S_CMP: begin
          if (ins) begin
            if (stored > qbyte) begin
              j     <= '0;
              state <= S_SH_RD;
            end else if ((stored < qbyte) || field_end) begin
              j     <= '0;
              state <= S_WQ_RD;
            end else begin
              j     <= j + 1'b1;
              state <= S_RD;
            end
          end else begin
            if (stored != qbyte) begin
              if (CNT_W'(ent + 1'b1) == count) begin
                result <= '{ST_NOT_FOUND, 6'd0, 7'(count)};
                state  <= S_IDLE;
              end else begin
                ent   <= ent + 1'b1;
                j     <= '0;
                state <= S_RD;
              end
            end else if (field_end) begin
              result <= '{ST_FOUND, 6'(ent), 7'(count)};
              state  <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (field_end) begin
            j <= '0;
            if (!ph) begin
              ph    <= 1'b1;
              state <= S_SH_RD;
            end else begin
              ph    <= 1'b0;
              ent   <= ent - 1'b1;
              state <= (ent == CNT_W'(1)) ? S_WQ_RD : S_RD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_SH_RD;
          end
        end
        S_WQ_RD: state <= S_WQ_WR;
        S_WQ_WR: begin
          if (field_end) begin
            j <= '0;
            if (!ph) begin
              ph    <= 1'b1;
              state <= S_WQ_RD;
            end else begin
              ph     <= 1'b0;
              count  <= count + 1'b1;
              result <= '{ST_INSERTED, 6'(ent), 7'(count + 1'b1)};
              state  <= S_IDLE;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_WQ_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("record count beyond table size");
  a_go_idle: assert property (@(posedge clk) disable iff (rst) req.go |-> state == S_IDLE)
    else $error("operation started while sequencer busy");
  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_INSERTED) |-> count == CNT_W'($past(count) + 1'b1))
    else $error("insert without count update");

endmodule

// ----- hw/rtl/sorted_string_record_table.sv -----
// ----------------------------------------------------------------------------
// sorted_string_record_table
// name/phone record table kept sorted by name, with insert and exact search
// ----------------------------------------------------------------------------
// character beats are taken while busy is low; a last beat starts the operation:
//   search: compares the query byte by byte against each stored entry in turn
//   insert: compares names from the last entry down, moves each larger entry
//           up one slot (name then phone), then writes the new record
// each byte step is a read of the registered store ram then a compare or write
// busy stays high through the result strobe cycle; results cannot be stalled
// synchronous reset empties the table at once, no clearing pass
module sorted_string_record_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sst_pkg::in_t  cmd,
  output logic          done,
  output sst_pkg::out_t result
);
  import sst_pkg::*;

  logic               accept;
  logic               op_ok;
  logic               to_name;
  logic               nonzero;
  logic               name_we;
  logic               phone_we;
  logic [NFILL_W-1:0] name_fill;
  logic [PFILL_W-1:0] phone_fill;
  logic [BYTE_IW-1:0] qidx;
  logic [7:0]         qname_rd;
  logic [7:0]         qphone_rd;
  op_req_t            req;

  // a beat is taken when start is high and the sequencer is not busy with an operation or its result strobe
  assign accept  = start && !busy;
  assign op_ok   = (cmd.op != OP_NONE);
  // insert routes by part, searches by their own op
  assign to_name = (cmd.op == OP_NAME) || ((cmd.op == OP_INSERT) && !cmd.part);
  assign nonzero = (cmd.char_byte != 8'd0);

  // overlong strings just stop growing
  assign name_we  = accept && op_ok && nonzero && to_name &&
                    (name_fill < NFILL_W'(NAME_BYTES));
  assign phone_we = accept && op_ok && nonzero && !to_name &&
                    (phone_fill < PFILL_W'(PHONE_BYTES));

  // fill counters stand in for clearing the query buffers: bytes at or past
  // the fill read as zero padding inside the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      name_fill  <= '0;
      phone_fill <= '0;
    end else if (done) begin
      name_fill  <= '0;
      phone_fill <= '0;
    end else begin
      if (name_we) begin
        name_fill <= name_fill + 1'b1;
      end
      if (phone_we) begin
        phone_fill <= phone_fill + 1'b1;
      end
    end
  end

  sst_ram #(.DEPTH(2 ** NAME_IW), .WIDTH(8)) u_qname (
    .clk(clk), .we(name_we), .waddr(name_fill[NAME_IW-1:0]), .wdata(cmd.char_byte),
    .raddr(qidx[NAME_IW-1:0]), .rdata(qname_rd)
  );

  sst_ram #(.DEPTH(2 ** PHONE_IW), .WIDTH(8)) u_qphone (
    .clk(clk), .we(phone_we), .waddr(phone_fill[PHONE_IW-1:0]), .wdata(cmd.char_byte),
    .raddr(qidx[PHONE_IW-1:0]), .rdata(qphone_rd)
  );

  // the last beat's own character lands in the buffer on the same edge the
  // operation starts, and the fills seen by the sequencer already include it
  assign req.go         = accept && op_ok && cmd.last;
  assign req.op         = cmd.op;
  assign req.name_fill  = name_fill;
  assign req.phone_fill = phone_fill;

  sst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req(req),
    .qname_rd(qname_rd), .qphone_rd(qphone_rd), .qidx(qidx),
    .busy(busy), .done(done), .result(result)
  );

endmodule

// ----- tb/sorted_string_record_table_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_string_record_table_test
// self-checking bench for the sorted name/phone record table
// ----------------------------------------------------------------------------
// an initial block queues character beats: a short directed set, then random
// insert and search sequences with noise beats mixed in. a clocked driver
// feeds them over start/busy and runs a table model on every accepted beat.
// a clocked monitor compares each done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_string_record_table_test;
  import sst_pkg::*;

  typedef logic [7:0] str_t[$];

  // one queued beat; hold makes the driver wait until the table is quiet
  typedef struct {
    in_t beat;
    bit  hold;
  } pending_t;

  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  cmd = '0;
  logic busy;
  logic done;
  out_t result;

  sorted_string_record_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pending_t beat_q[$];
  out_t     status_q[$];
  int       fail_cnt = 0;
  int       sent_cnt = 0;
  int       quiet_cycles = 0;

  // model of the table contents
  logic [7:0] tbl_name [ENTRIES][NAME_BYTES];
  logic [7:0] tbl_phone[ENTRIES][PHONE_BYTES];
  int         tbl_cnt = 0;
  logic [7:0] q_name [NAME_BYTES];
  logic [7:0] q_phone[PHONE_BYTES];
  int         n_fill = 0;
  int         p_fill = 0;

  // pools of stored strings so searches hit often
  str_t name_pool[$];
  str_t phone_pool[$];

  function automatic void clear_query();
    for (int i = 0; i < NAME_BYTES; i++) q_name[i] = '0;
    for (int i = 0; i < PHONE_BYTES; i++) q_phone[i] = '0;
    n_fill = 0;
    p_fill = 0;
  endfunction

  // unsigned byte compare of a stored name against the query name
  function automatic int name_order(int idx);
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (tbl_name[idx][i] > q_name[i]) return 1;
      if (tbl_name[idx][i] < q_name[i]) return -1;
    end
    return 0;
  endfunction

  function automatic bit phone_equal(int idx);
    for (int i = 0; i < PHONE_BYTES; i++)
      if (tbl_phone[idx][i] != q_phone[i]) return 0;
    return 1;
  endfunction

  // advance the table model by one accepted beat
  function automatic void table_step(in_t b);
    out_t r;
    int   p;
    bit   hit;
    r = '0;
    if (b.op == OP_NONE) return;
    if (b.op == OP_NAME || (b.op == OP_INSERT && !b.part)) begin
      if (b.char_byte != 0 && n_fill < NAME_BYTES) begin
        q_name[n_fill] = b.char_byte;
        n_fill++;
      end
    end else if (b.char_byte != 0 && p_fill < PHONE_BYTES) begin
      q_phone[p_fill] = b.char_byte;
      p_fill++;
    end
    if (!b.last) return;
    if (b.op == OP_INSERT) begin
      if (tbl_cnt >= ENTRIES) begin
        r.status = ST_FULL;
      end else begin
        p = tbl_cnt;
        // equal names stay ahead of the new one
        while (p > 0 && name_order(p - 1) > 0) begin
          tbl_name[p]  = tbl_name[p - 1];
          tbl_phone[p] = tbl_phone[p - 1];
          p--;
        end
        tbl_name[p]  = q_name;
        tbl_phone[p] = q_phone;
        tbl_cnt++;
        r.status   = ST_INSERTED;
        r.position = p[5:0];
      end
    end else begin
      r.status = ST_NOT_FOUND;
      for (int i = 0; i < tbl_cnt; i++) begin
        hit = (b.op == OP_NAME) ? (name_order(i) == 0) : phone_equal(i);
        if (hit) begin
          r.status   = ST_FOUND;
          r.position = i[5:0];
          break;
        end
      end
    end
    r.count_now = tbl_cnt[6:0];
    status_q.push_back(r);
    clear_query();
  endfunction

  function automatic void push_beat(logic [1:0] op, logic part, logic [7:0] c,
                                    logic last, bit hold);
    pending_t pb;
    pb.beat.op        = op;
    pb.beat.part      = part;
    pb.beat.char_byte = c;
    pb.beat.last      = last;
    pb.hold           = hold;
    beat_q.push_back(pb);
  endfunction

  // queue a whole operation; part bit is random for searches, noise mixed in
  function automatic void push_op(logic [1:0] op, str_t nm, str_t ph, bit mix);
    logic [8:0] seq[$];
    logic [8:0] t;
    int         j;
    foreach (nm[i]) seq.push_back({1'b0, nm[i]});
    foreach (ph[i]) seq.push_back({1'b1, ph[i]});
    if (mix) begin
      for (int i = seq.size() - 1; i > 0; i--) begin
        j = $urandom_range(i, 0);
        t = seq[i]; seq[i] = seq[j]; seq[j] = t;
      end
    end
    if (seq.size() == 0) seq.push_back({1'b0, 8'h00});
    foreach (seq[i]) begin
      if ($urandom_range(99, 0) < 3)
        push_beat(OP_NONE, 1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)),
                  1'($urandom_range(1, 0)), 0);
      if ($urandom_range(99, 0) < 3) push_beat(op, seq[i][8], 8'h00, 1'b0, 0);
      push_beat(op, (op == OP_INSERT) ? seq[i][8] : 1'($urandom_range(1, 0)),
                seq[i][7:0], i == seq.size() - 1, 0);
    end
  endfunction

  function automatic str_t rand_str(int max_len);
    str_t s;
    int   len;
    len = ($urandom_range(99, 0) < 2) ? $urandom_range(max_len + 6, max_len)
                                      : $urandom_range(5, 0);
    for (int i = 0; i < len; i++)
      s.push_back(($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 1))
                                              : 8'($urandom_range(8'h63, 8'h61)));
    return s;
  endfunction

  // driver: beat moves at an edge with start high and busy low
  always @(posedge clk) begin
    int       idle_pct;
    pending_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        table_step(cmd);
        sent_cnt++;
      end
      idle_pct = (sent_cnt < 450) ? 6 : (sent_cnt < 900) ? 57 : 0;
      if (start && busy) begin
        // keep the current beat on the bus
      end else if (beat_q.size() > 0 && $urandom_range(99, 0) >= idle_pct &&
                   (!beat_q[0].hold || status_q.size() == 0)) begin
        nxt    = beat_q.pop_front();
        cmd   <= nxt.beat;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be held off, so each done is checked at once
  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (status_q.size() == 0) begin
        $error("result with nothing expected: %p", result);
        fail_cnt++;
      end else begin
        want = status_q.pop_front();
        if (result.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, result.status);
          fail_cnt++;
        end
        if (result.position !== want.position) begin
          $error("position expected %0d actual %0d", want.position, result.position);
          fail_cnt++;
        end
        if (result.count_now !== want.count_now) begin
          $error("count_now expected %0d actual %0d", want.count_now, result.count_now);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    str_t nm;
    str_t ph;
    int   k;
    clear_query();

    // directed: ordering, duplicates, extreme bytes, empty strings
    push_op(OP_INSERT, '{8'h62}, '{8'h31, 8'h32}, 0);
    push_op(OP_INSERT, '{8'h61}, '{8'h39}, 0);
    push_op(OP_INSERT, '{8'h62}, '{8'h33}, 0);
    push_op(OP_INSERT, '{8'hff, 8'h01}, '{8'hff}, 1);
    push_op(OP_INSERT, '{}, '{}, 0);
    push_beat(OP_NONE, 1'b1, 8'hff, 1'b1, 0);
    push_op(OP_NAME, '{8'h62}, '{}, 0);
    push_op(OP_NAME, '{8'h7a, 8'h7a}, '{}, 0);
    push_op(OP_PHONE, '{}, '{8'h31, 8'h32}, 0);
    push_op(OP_PHONE, '{}, '{8'h01}, 0);
    push_beat(OP_NAME, 1'b0, 8'h00, 1'b1, 0);
    // wait for the table to go quiet before the random part
    push_beat(OP_NAME, 1'b1, 8'hff, 1'b1, 1);

    while (beat_q.size() < 1350) begin
      k = $urandom_range(99, 0);
      if (k < 48) begin
        nm = rand_str(NAME_BYTES);
        ph = rand_str(PHONE_BYTES);
        name_pool.push_back(nm);
        phone_pool.push_back(ph);
        push_op(OP_INSERT, nm, ph, $urandom_range(9, 0) == 0);
      end else if (k < 74) begin
        nm = (name_pool.size() > 0 && $urandom_range(99, 0) < 70)
             ? name_pool[$urandom_range(name_pool.size() - 1, 0)] : rand_str(NAME_BYTES);
        push_op(OP_NAME, nm, '{}, 0);
      end else begin
        ph = (phone_pool.size() > 0 && $urandom_range(99, 0) < 70)
             ? phone_pool[$urandom_range(phone_pool.size() - 1, 0)] : rand_str(PHONE_BYTES);
        push_op(OP_PHONE, '{}, ph, 0);
      end
      if ($urandom_range(99, 0) < 2) beat_q[beat_q.size() - 1].hold = 1;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (beat_q.size() > 0 || start) @(posedge clk);
    while (status_q.size() > 0) @(posedge clk);
    repeat (64) @(posedge clk);

    if (fail_cnt == 0 && status_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sst_pkg.sv
hw/rtl/sst_ram.sv
hw/rtl/sst_ctrl.sv
hw/rtl/sorted_string_record_table.sv
tb/sorted_string_record_table_test.sv
